// ===== rtl/sgf_pkg.sv =====
// ---------------------------------------------------------------------------
// sgf_pkg
// Shared types and constants of the Savitzky-Golay smoothing filter.
// ---------------------------------------------------------------------------
package sgf_pkg;

	// request kinds on the input channel
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;

	localparam int COEF_BITS = 18;
	localparam int IDX_BITS  = 5;
	localparam int POS_BITS  = 16;
	localparam logic [IDX_BITS-1:0] FRAME_RESET = IDX_BITS'(5);

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/sgf_ram.sv =====
// ---------------------------------------------------------------------------
// sgf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module sgf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/savitzky_golay_smoothing_filter.sv =====
// ---------------------------------------------------------------------------
// savitzky_golay_smoothing_filter
// Streaming Savitzky-Golay smoother: window and coefficient table in RAMs,
// one shared multiply-accumulate walks the F taps of each output row.
// ---------------------------------------------------------------------------
// Sequencing: each output row steps through ROW, MAC, DRAIN, ROUND and OUT;
//   no new word is accepted until every output of the last sample is taken.
// The single shared MAC reads one tap from each RAM per cycle while in MAC,
//   walking the F taps of the current row.
// Reset: arst_n clears pointer, fill count, output index, frame_length to 5;
//   RAM contents are undefined until written.
module savitzky_golay_smoothing_filter #(
	parameter int MAX_FRAME      = 31,
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [4:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          sample_last,
	input  logic [4:0]                    coef_row,
	input  logic [4:0]                    coef_col,
	input  logic signed [17:0]            coef_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] smoothed,
	output logic [15:0]                   position,
	output logic                          run_last,
	output logic                          signal_last,
	output logic                          too_short
);

	localparam int FB = $clog2(MAX_FRAME + 1);
	localparam int WB = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam int CDEPTH = MAX_FRAME * MAX_FRAME;
	localparam int CB = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int PB = SAMPLE_BITS + sgf_pkg::COEF_BITS;
	localparam int AB = PB + FB;
	localparam int MAXODD = (MAX_FRAME % 2 == 1) ? MAX_FRAME : MAX_FRAME - 1;
	localparam logic [FB-1:0] MAXF = FB'(MAX_FRAME);

	sgf_pkg::state_t state_q, state_d;

	logic [4:0]      frame_q;
	logic [WB-1:0]   wptr_q;
	logic [FB-1:0]   fill_q;
	logic [15:0]     oidx_q;
	logic [FB-1:0]   f_q;      // frame latched for the current sample
	logic [FB-1:0]   row_q;    // current row
	logic [FB-1:0]   rend_q;   // last row to produce
	logic [FB-1:0]   k_q;      // tap counter
	logic [WB-1:0]   sidx_q;   // window read address
	logic [CB-1:0]   cidx_q;   // table read address
	logic            last_q;   // final sample of the signal
	logic            rd_s1, rd_s2;
	logic signed [PB-1:0] prod_s2;
	logic signed [AB-1:0] acc_q;

	logic [FB-1:0] f_eff;
	logic [FB-1:0] f_or;

	// effective frame: force odd, clamp to the largest odd value in range
	always_comb begin
		f_or = FB'({frame_q[4:1], 1'b1});
		if (({1'b0, frame_q} | 6'd1) > 6'(MAX_FRAME)) begin
			f_eff = FB'(MAXODD);
		end else begin
			f_eff = f_or;
		end
	end

	// ram ports
	logic                   in_acc;
	logic                   coef_we;
	logic [CB-1:0]          coef_waddr;
	logic                   samp_we;
	logic signed [17:0]     coef_rd;
	logic [SAMPLE_BITS-1:0] samp_rd;

	assign in_acc     = in_valid && in_ready;
	assign coef_we    = in_acc && req_type == sgf_pkg::REQ_COEF
		&& {1'b0, coef_row} < 6'(MAX_FRAME) && {1'b0, coef_col} < 6'(MAX_FRAME);
	assign coef_waddr = CB'(coef_row * MAX_FRAME + coef_col);
	assign samp_we    = in_acc && req_type == sgf_pkg::REQ_SAMPLE;

	sgf_ram #(.WIDTH(sgf_pkg::COEF_BITS), .DEPTH(CDEPTH)) u_coef (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_value),
		.raddr (cidx_q),
		.rdata (coef_rd)
	);

	sgf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAME)) u_win (
		.clk   (clk),
		.we    (samp_we),
		.waddr (wptr_q),
		.wdata (sample),
		.raddr (sidx_q),
		.rdata (samp_rd)
	);

	// sample bookkeeping on acceptance
	logic [FB-1:0] fill_new;
	logic          leading;
	logic          short_sig;
	logic [FB-1:0] half;
	assign half     = f_eff >> 1;
	assign fill_new = (fill_q < MAXF) ? fill_q + FB'(1) : fill_q;
	assign leading  = (fill_q < MAXF) && (fill_new == f_eff);
	assign short_sig = fill_new < f_eff;

	// window start slot (oldest of last F samples), pointer already advanced
	logic [WB-1:0] wptr_next;
	logic [WB:0]   base_w;
	assign wptr_next = ({1'b0, wptr_q} == (WB+1)'(MAX_FRAME - 1)) ? '0 : wptr_q + WB'(1);
	always_comb begin
		base_w = (WB+1)'(wptr_q) + (WB+1)'(MAX_FRAME) - (WB+1)'(f_q);
		if (base_w >= (WB+1)'(MAX_FRAME)) begin
			base_w = base_w - (WB+1)'(MAX_FRAME);
		end
	end

	// rounding and saturation of the accumulator
	localparam logic signed [AB-1:0] HI = AB'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
	localparam logic signed [AB-1:0] LO = -HI - AB'(1);
	logic signed [AB-1:0] rnd;
	logic signed [AB-1:0] q;
	logic [SAMPLE_BITS-1:0] sat;
	assign rnd = acc_q + AB'(64'sd1 <<< (COEF_FRAC_BITS-1));
	assign q   = rnd >>> COEF_FRAC_BITS;
	assign sat = (q > HI) ? HI[SAMPLE_BITS-1:0] :
		(q < LO) ? LO[SAMPLE_BITS-1:0] : q[SAMPLE_BITS-1:0];

	assign cfg_ready = (state_q == sgf_pkg::ST_IDLE) && !out_valid;
	assign in_ready  = (state_q == sgf_pkg::ST_IDLE) && !out_valid;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sgf_pkg::ST_IDLE: begin
				if (in_acc && req_type == sgf_pkg::REQ_SAMPLE && !short_sig) begin
					state_d = sgf_pkg::ST_ROW;
				end
			end
			sgf_pkg::ST_ROW:   state_d = sgf_pkg::ST_MAC;
			sgf_pkg::ST_MAC: begin
				if (k_q == f_q - FB'(1)) begin
					state_d = sgf_pkg::ST_DRAIN;
				end
			end
			sgf_pkg::ST_DRAIN: begin
				if (!rd_s1 && !rd_s2) begin
					state_d = sgf_pkg::ST_ROUND;
				end
			end
			sgf_pkg::ST_ROUND: state_d = sgf_pkg::ST_OUT;
			sgf_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = (row_q == rend_q) ? sgf_pkg::ST_IDLE : sgf_pkg::ST_ROW;
				end
			end
			default: state_d = sgf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= sgf_pkg::FRAME_RESET;
			wptr_q    <= '0;
			fill_q    <= '0;
			oidx_q    <= '0;
			out_valid <= 1'b0;
			rd_s1     <= 1'b0;
			rd_s2     <= 1'b0;
		end else begin
			rd_s1 <= (state_q == sgf_pkg::ST_MAC);
			rd_s2 <= rd_s1;
			if (cfg_valid && cfg_ready) begin
				frame_q <= cfg_data;
			end
			if (samp_we) begin
				wptr_q <= wptr_next;
				if (short_sig && sample_last) begin
					fill_q    <= '0;
					oidx_q    <= '0;
					out_valid <= 1'b1;
				end else begin
					fill_q <= fill_new;
				end
			end
			if (state_q == sgf_pkg::ST_ROUND) begin
				out_valid <= 1'b1;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
				if (state_q == sgf_pkg::ST_OUT) begin
					if (row_q == rend_q && last_q) begin
						fill_q <= '0;
						oidx_q <= '0;
					end else begin
						oidx_q <= oidx_q + 16'd1;
					end
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (samp_we) begin
			f_q    <= f_eff;
			last_q <= sample_last;
			row_q  <= leading ? '0 : half;
			rend_q <= sample_last ? f_eff - FB'(1) : half;
			if (short_sig && sample_last) begin
				smoothed    <= '0;
				position    <= '0;
				run_last    <= 1'b1;
				signal_last <= 1'b1;
				too_short   <= 1'b1;
			end
		end
		case (state_q)
			sgf_pkg::ST_ROW: begin
				k_q    <= '0;
				acc_q  <= '0;
				sidx_q <= WB'(base_w);
				cidx_q <= CB'(row_q * MAX_FRAME);
			end
			sgf_pkg::ST_MAC: begin
				k_q    <= k_q + FB'(1);
				sidx_q <= ({1'b0, sidx_q} == (WB+1)'(MAX_FRAME - 1)) ? '0 : sidx_q + WB'(1);
				cidx_q <= cidx_q + CB'(1);
			end
			sgf_pkg::ST_ROUND: begin
				smoothed    <= sat;
				position    <= oidx_q;
				run_last    <= (row_q == rend_q);
				signal_last <= (row_q == rend_q) && last_q;
				too_short   <= 1'b0;
			end
			sgf_pkg::ST_OUT: begin
				if (out_ready) begin
					row_q <= row_q + FB'(1);
				end
			end
			default: begin
			end
		endcase
		// multiply stage then accumulate
		if (rd_s1) begin
			prod_s2 <= PB'(coef_rd) * PB'($signed(samp_rd));
		end
		if (rd_s2) begin
			acc_q <= acc_q + AB'(prod_s2);
		end
	end

`ifndef SYNTHESIS
	// no new word accepted while a result is pending
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted with pending result");
	// result appears only after rounding or on a short signal
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == sgf_pkg::ST_ROUND) || $past(samp_we))
		else $error("unexpected result");
	// accumulation ends before rounding
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sgf_pkg::ST_ROUND |-> !rd_s2)
		else $error("rounding with mac in flight");
`endif

endmodule
